/* rtl/core/psll_pkg.sv */
`default_nettype none

package psll_pkg;

  // Default depth of each vectoring CORDIC
  localparam int CORDIC_STAGES_DEF = 24;

  // Datapath widths
  localparam int XW = 58;          // CORDIC x/y, signed, Q.33 pixel units
  localparam int ZW = 45;          // CORDIC angle, signed radians Q.40
  localparam int DW = 24;          // degree quotient bits, Q.16
  localparam int LW = 27;          // signed working width for lon/lat

  // Register indexes on the config port
  localparam logic [1:0] REG_OFFSET_X     = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y     = 2'd1;
  localparam logic [1:0] REG_FULL_WIDTH   = 2'd2;
  localparam logic [1:0] REG_SCALE_FACTOR = 2'd3;

  // Angle constants, radians Q.40
  localparam logic [39:0] QPI_Q40  = 40'd863554413089;    // pi/4
  localparam logic [39:0] HALF_QPI = 40'd431777206544;    // floor(pi/4 / 2)
  localparam logic signed [ZW-1:0] PI_Q40 = 45'sd3454217652356;

  // Inverse CORDIC gain, Q0.32
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  // Degrees, Q.16
  localparam logic signed [LW-1:0] DEG90  = 27'sd5898240;
  localparam logic signed [LW-1:0] DEG180 = 27'sd11796480;
  localparam logic signed [LW-1:0] DEG360 = 27'sd23592960;

  // Longitude special-case flags, follow the item down the pipe
  typedef struct packed {
    logic py_zero;
    logic px_pos;
  } lon_flags_t;

  // atan(2^-idx) in radians Q.40, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_rom(input int idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:       v = 45'sd863554413089;
      1:       v = 45'sd509785937287;
      2:       v = 45'sd269356888665;
      3:       v = 45'sd136729762476;
      4:       v = 45'sd68630207382;
      5:       v = 45'sd34348560106;
      6:       v = 45'sd17178471287;
      7:       v = 45'sd8589759836;
      8:       v = 45'sd4294945451;
      9:       v = 45'sd2147480917;
      10:      v = 45'sd1073741483;
      11:      v = 45'sd536870869;
      12:      v = 45'sd268435451;
      13:      v = 45'sd134217727;
      default: v = ZW'(1) << (40 - idx);  // atan(t) rounds to t here
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/psll_cordic.sv */
`default_nettype none

module psll_cordic #(
  parameter int STAGES = psll_pkg::CORDIC_STAGES_DEF,
  parameter int SW     = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_v,
  input  wire logic signed [psll_pkg::XW-1:0] x_i,
  input  wire logic signed [psll_pkg::XW-1:0] y_i,
  input  wire logic [SW-1:0]                  sb_i,
  output logic                                out_v,
  output logic signed [psll_pkg::XW-1:0]      mag_o,
  output logic signed [psll_pkg::ZW-1:0]      ang_o,
  output logic [SW-1:0]                       sb_o
);
  import psll_pkg::*;

  logic                 v_r  [0:STAGES];
  logic signed [XW-1:0] x_r  [0:STAGES];
  logic signed [XW-1:0] y_r  [0:STAGES];
  logic signed [ZW-1:0] z_r  [0:STAGES];
  logic [SW-1:0]        sb_r [0:STAGES];

  logic signed [XW-1:0] x0_nxt, y0_nxt;
  logic signed [ZW-1:0] z0_nxt;

  // Left half-plane: turn by pi so the iterations converge
  always_comb begin
    x0_nxt = x_i;
    y0_nxt = y_i;
    z0_nxt = '0;
    if (x_i < 0) begin
      z0_nxt = (y_i >= 0) ? PI_Q40 : -PI_Q40;
      x0_nxt = -x_i;
      y0_nxt = -y_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= x0_nxt;
      y_r[0]  <= y0_nxt;
      z_r[0]  <= z0_nxt;
      sb_r[0] <= sb_i;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ANG = atan_rom(i);
    logic signed [XW-1:0] dx, dy, x_nxt, y_nxt;
    logic signed [ZW-1:0] z_nxt;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      if (y_r[i] >= 0) begin
        x_nxt = x_r[i] + dx;
        y_nxt = y_r[i] - dy;
        z_nxt = z_r[i] + ANG;
      end else begin
        x_nxt = x_r[i] - dx;
        y_nxt = y_r[i] + dy;
        z_nxt = z_r[i] - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]  <= x_nxt;
        y_r[i+1]  <= y_nxt;
        z_r[i+1]  <= z_nxt;
        sb_r[i+1] <= sb_r[i];
      end
    end
  end

  assign out_v = v_r[STAGES];
  assign mag_o = x_r[STAGES];
  assign ang_o = z_r[STAGES];
  assign sb_o  = sb_r[STAGES];

endmodule

`default_nettype wire

/* rtl/core/psll_deg.sv */
`default_nettype none

// Two lanes of radians Q.40 to degrees Q.16, rounded half away from zero.
// Quotient by pi/4 comes from a reciprocal product, then a remainder check
// adds back at most two.
module psll_deg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_v,
  input  wire logic signed [psll_pkg::ZW-1:0] lon_ang_i,
  input  wire logic signed [psll_pkg::ZW-1:0] lat_ang_i,
  input  wire psll_pkg::lon_flags_t           flags_i,
  output logic                                out_v,
  output logic [psll_pkg::DW-1:0]             lon_deg_o,
  output logic                                lon_neg_o,
  output logic [psll_pkg::DW-1:0]             lat_deg_o,
  output logic                                lat_neg_o,
  output psll_pkg::lon_flags_t                flags_o
);
  import psll_pkg::*;

  // abs, reciprocal product, estimate, back-multiply, remainder, correct
  localparam int NS = 6;
  localparam int EW = DW + 2;   // estimate width

  // floor(45 * 2^16 * 2^42 / (pi/4 in Q.40)); estimate = |ang| * RECIP >> 42
  localparam logic [23:0] RECIP  = 24'((64'd2949120 << 42) / 64'(QPI_Q40));
  localparam logic [31:0] QPI_LO = QPI_Q40[31:0];
  localparam logic [7:0]  QPI_HI = QPI_Q40[39:32];
  localparam logic [63:0] QPI_X1 = 64'(QPI_Q40);
  localparam logic [63:0] QPI_X2 = 64'(QPI_Q40) << 1;

  logic         v_r  [0:NS-1];
  lon_flags_t   fl_r [0:NS-1];

  logic signed [ZW-1:0] ang_in [2];
  logic                 neg_r  [2][0:NS-1];
  logic [DW-1:0]        q_r    [2];

  assign ang_in[0] = lon_ang_i;
  assign ang_in[1] = lat_ang_i;

  // Valid and flags ride alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= flags_i;
    end
  end

  for (genvar j = 0; j < NS - 1; j++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[j+1] <= fl_r[j];
      end
    end
  end

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic [ZW-1:0] m_r;
    logic [63:0]   m64;
    logic [63:0]   n_nxt;
    logic [46:0]   pa_r;
    logic [45:0]   pb_r;
    logic [63:0]   n1_r, n2_r, n3_r;
    logic [47:0]   e_sum;
    logic [EW-1:0] e2_r, e3_r, e4_r, e_nxt;
    logic [57:0]   pql_r;
    logic [33:0]   pqh_r;
    logic [63:0]   rem_r;

    // Dividend: |ang| * 45 * 2^16 + floor(q/2)
    always_comb begin
      m64   = 64'(m_r);
      n_nxt = (((m64 << 5) + (m64 << 3) + (m64 << 2) + m64) << 16) + 64'(HALF_QPI);
    end

    // Estimate never exceeds the quotient and is at most two below it
    assign e_sum = 48'(pa_r) + 48'(pb_r[45:22]);

    // Remainder decides how many divisors are still left
    always_comb begin
      priority if (rem_r >= QPI_X2) begin
        e_nxt = e4_r + EW'(2);
      end else if (rem_r >= QPI_X1) begin
        e_nxt = e4_r + EW'(1);
      end else begin
        e_nxt = e4_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r          <= (ang_in[ln] < 0) ? ZW'(-ang_in[ln]) : ZW'(ang_in[ln]);
        neg_r[ln][0] <= (ang_in[ln] < 0);
        pa_r         <= 47'(m_r[ZW-1:22]) * 47'(RECIP);
        pb_r         <= 46'(m_r[21:0]) * 46'(RECIP);
        n1_r         <= n_nxt;
        e2_r         <= e_sum[EW+19:20];
        n2_r         <= n1_r;
        pql_r        <= 58'(e2_r) * 58'(QPI_LO);
        pqh_r        <= 34'(e2_r) * 34'(QPI_HI);
        e3_r         <= e2_r;
        n3_r         <= n2_r;
        rem_r        <= n3_r - (64'(pql_r) + (64'(pqh_r) << 32));
        e4_r         <= e3_r;
        q_r[ln]      <= e_nxt[DW-1:0];
        for (int k = 0; k < NS - 1; k++) begin
          neg_r[ln][k+1] <= neg_r[ln][k];
        end
      end
    end
  end

  assign out_v     = v_r[NS-1];
  assign flags_o   = fl_r[NS-1];
  assign lon_deg_o = q_r[0];
  assign lon_neg_o = neg_r[0][NS-1];
  assign lat_deg_o = q_r[1];
  assign lat_neg_o = neg_r[1][NS-1];

endmodule

`default_nettype wire

/* rtl/core/polar_stereo_pixel_to_lonlat.sv */
`default_nettype none

// Pixel to longitude/latitude through an inverse north-polar stereographic
// projection.
// Input channel: in_valid/in_stall with in_pixel_x, in_pixel_y (unsigned).
// Result channel: out_valid/out_stall with out_longitude (25 bit) and
// out_latitude (24 bit), both signed degrees in 1/65536 degree units.
// Config port: cfg_we writes cfg_data into register cfg_index (offset_x,
// offset_y, full_width, scale_factor); write only while the block is idle.
// Throughput: one item per cycle while in_stall is low.
// Path: stage A, stage B, two vectoring CORDICs in series (angle, then atan
// of the magnitude), gain removal, a 6-stage radians-to-degrees conversion,
// stage F and the output register.
// Reset: clears all pipeline valids and loads the register defaults.
// Stall: a two-entry output (result register plus skid) lets one more item
// leave the pipe while the receiver stalls; after that in_stall rises and
// the whole pipe holds.
module polar_stereo_pixel_to_lonlat #(
  parameter int CORDIC_STAGES = psll_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_pixel_x,
  input  wire logic [15:0] in_pixel_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [24:0] out_longitude,
  output logic signed [23:0] out_latitude
);
  import psll_pkg::*;

  localparam int SW2 = $bits(lon_flags_t) + ZW;

  // Configuration registers
  logic [19:0] offset_x_r, offset_y_r;
  logic [20:0] full_width_r;
  logic [31:0] scale_factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r     <= '0;
      offset_y_r     <= '0;
      full_width_r   <= 21'd1024;
      scale_factor_r <= 32'd4194304;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_X:     offset_x_r     <= cfg_data[19:0];
        REG_OFFSET_Y:     offset_y_r     <= cfg_data[19:0];
        REG_FULL_WIDTH:   full_width_r   <= cfg_data[20:0];
        REG_SCALE_FACTOR: scale_factor_r <= cfg_data;
      endcase
    end
  end

  // Whole pipe advances while the skid entry is free
  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // Stage A: half-pixel distances from the frame center
  logic [20:0]        sum_x, sum_y;
  logic               va_r;
  logic signed [22:0] dx_r, dy_r;

  assign sum_x = 21'(in_pixel_x) + 21'(offset_x_r);
  assign sum_y = 21'(in_pixel_y) + 21'(offset_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= $signed({1'b0, sum_x, 1'b0}) - $signed({2'b00, full_width_r});
      dy_r <= $signed({2'b00, full_width_r}) - $signed({1'b0, sum_y, 1'b0});
    end
  end

  // Stage B: scale into Q.33
  logic               vb_r;
  logic signed [55:0] px_r, py_r;
  lon_flags_t         flb_r;
  logic signed [32:0] scale_s;

  assign scale_s = $signed({1'b0, scale_factor_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r          <= dx_r * scale_s;
      py_r          <= dy_r * scale_s;
      flb_r.py_zero <= (dy_r == 23'sd0) || (scale_factor_r == 32'd0);
      flb_r.px_pos  <= (dx_r > 23'sd0) && (scale_factor_r != 32'd0);
    end
  end

  // CORDIC 1: angle of (py, px) and scaled radius
  logic                 vc1;
  logic signed [XW-1:0] mag1;
  logic signed [ZW-1:0] ang1;
  lon_flags_t           flc1;

  psll_cordic #(
    .STAGES (CORDIC_STAGES),
    .SW     ($bits(lon_flags_t))
  ) u_cordic_lon (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (vb_r),
    .x_i   (XW'(py_r)),
    .y_i   (XW'(px_r)),
    .sb_i  (flb_r),
    .out_v (vc1),
    .mag_o (mag1),
    .ang_o (ang1),
    .sb_o  (flc1)
  );

  // Gain removal: radius * INV_GAIN in two 32-bit-wide partial products
  logic                 vg1_r, vg2_r;
  logic [57:0]          ph_r;
  logic [31:0]          pl_r;
  logic signed [ZW-1:0] zg1_r, zg2_r;
  lon_flags_t           flg1_r, flg2_r;
  logic [56:0]          r_r;
  logic [63:0]          pl_full;

  assign pl_full = 64'(mag1[31:0]) * 64'(INV_GAIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vg1_r <= 1'b0;
      vg2_r <= 1'b0;
    end else if (en) begin
      vg1_r <= vc1;
      vg2_r <= vg1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r   <= 58'(mag1[XW-1:32]) * 58'(INV_GAIN);
      pl_r   <= pl_full[63:32];
      zg1_r  <= ang1;
      flg1_r <= flc1;
      r_r    <= 57'(ph_r) + 57'(pl_r);
      zg2_r  <= zg1_r;
      flg2_r <= flg1_r;
    end
  end

  // CORDIC 2: atan(radius), x fixed at one in Q.33
  logic                 vc2;
  logic signed [ZW-1:0] ang2;
  logic [SW2-1:0]       sb2;
  lon_flags_t           flc2;
  logic signed [ZW-1:0] zc2;

  psll_cordic #(
    .STAGES (CORDIC_STAGES),
    .SW     (SW2)
  ) u_cordic_lat (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .in_v  (vg2_r),
    .x_i   (XW'(64'd1 << 33)),
    .y_i   ($signed({1'b0, r_r})),
    .sb_i  ({flg2_r, zg2_r}),
    .out_v (vc2),
    .mag_o (),
    .ang_o (ang2),
    .sb_o  (sb2)
  );

  assign flc2 = sb2[SW2-1:ZW];
  assign zc2  = sb2[ZW-1:0];

  // Radians to degrees, both lanes
  logic          vd;
  logic [DW-1:0] lon_d, lat_d;
  logic          lon_neg, lat_neg;
  lon_flags_t    fld;

  psll_deg u_deg (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (vc2),
    .lon_ang_i (zc2),
    .lat_ang_i (ang2 <<< 1),
    .flags_i   (flc2),
    .out_v     (vd),
    .lon_deg_o (lon_d),
    .lon_neg_o (lon_neg),
    .lat_deg_o (lat_d),
    .lat_neg_o (lat_neg),
    .flags_o   (fld)
  );

  // Stage F: mirror, wrap and clamp, with the py-zero axis case for longitude
  logic signed [LW-1:0] dl, dt, lon_t, lat_t, lon_w, lat_w;
  logic                 vf_r;
  logic signed [24:0]   lon_f_r;
  logic signed [23:0]   lat_f_r;

  always_comb begin
    dl    = $signed({3'b000, lon_d});
    dt    = $signed({3'b000, lat_d});
    lon_t = lon_neg ? (DEG180 + dl) : (DEG180 - dl);
    lat_t = lat_neg ? (DEG90 + dt) : (DEG90 - dt);

    priority if (fld.py_zero) begin
      lon_w = fld.px_pos ? DEG90 : -DEG90;
    end else if (lon_t > DEG180) begin
      lon_w = lon_t - DEG360;
    end else if (lon_t <= -DEG180) begin
      lon_w = lon_t + DEG360;
    end else begin
      lon_w = lon_t;
    end

    priority if (lat_t > DEG90) begin
      lat_w = DEG90;
    end else if (lat_t < -DEG90) begin
      lat_w = -DEG90;
    end else begin
      lat_w = lat_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lon_f_r <= 25'(lon_w);
      lat_f_r <= 24'(lat_w);
    end
  end

  // Output register plus skid entry
  logic               out_v_r;
  logic signed [24:0] out_lon_r, skid_lon_r;
  logic signed [23:0] out_lat_r, skid_lat_r;
  logic               out_hold;

  assign out_hold = out_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_hold) begin
      if (vf_r && en) begin
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_hold) begin
      if (en) begin
        skid_lon_r <= lon_f_r;
        skid_lat_r <= lat_f_r;
      end
    end else if (skid_v_r) begin
      out_lon_r <= skid_lon_r;
      out_lat_r <= skid_lat_r;
    end else begin
      out_lon_r <= lon_f_r;
      out_lat_r <= lat_f_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_longitude = out_lon_r;
  assign out_latitude  = out_lat_r;

endmodule

`default_nettype wire

/* tb/sv/polar_stereo_pixel_to_lonlat_test.sv */
`default_nettype none

module polar_stereo_pixel_to_lonlat_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psll_pkg::*;

  localparam int STAGES = 24;
  localparam int PIPE_LAT = 2 * STAGES + 13;
  localparam longint DEG45 = 2949120;
  localparam longint D90 = 5898240;
  localparam longint D180 = 11796480;
  localparam longint D360 = 23592960;
  localparam longint unsigned GAIN_INV = 64'h9B74EDA8;

  typedef struct {
    logic signed [24:0] lon;
    logic signed [23:0] lat;
  } lonlat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_OFFSET_X;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_pixel_x = '0;
  logic [15:0] in_pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [24:0] out_longitude;
  logic signed [23:0] out_latitude;

  polar_stereo_pixel_to_lonlat dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel_x(in_pixel_x), .in_pixel_y(in_pixel_y),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_longitude(out_longitude), .out_latitude(out_latitude)
  );

  // Local register copies
  longint frame_ox = 0;
  longint frame_oy = 0;
  longint frame_fw = 1024;
  longint frame_scale = 4194304;

  longint atan_tab[STAGES];
  longint qpi;
  lonlat_t pending_coords[$];
  int errors = 0;
  bit quiet = 1'b0;

  initial forever #2 clk = ~clk;

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // atan(1/n) in Q.60 via alternating series
  function automatic longint unsigned atan_recip(longint unsigned n);
    longint unsigned p, acc, nn;
    p = (64'd1 << 60) / n;
    acc = p;
    nn = n * n;
    for (int k = 1; k < 64; k++) begin
      p = p / nn;
      if (p == 0) break;
      if (k & 1) acc = acc - p / (2 * k + 1);
      else acc = acc + p / (2 * k + 1);
    end
    return acc;
  endfunction

  function automatic longint to_q40(longint unsigned v);
    return longint'((v + (64'd1 << 19)) >> 20);
  endfunction

  task automatic fill_atan_table();
    qpi = to_q40(4 * atan_recip(5) - atan_recip(239));
    atan_tab[0] = qpi;
    for (int i = 1; i < STAGES; i++) atan_tab[i] = to_q40(atan_recip(64'd1 << i));
  endtask

  // Vectoring rotation: angle in Q.40 radians, magnitude times gain
  function automatic longint vector_angle(longint xv, longint yv, output longint mag);
    longint z, sx, sy;
    z = 0;
    if (xv < 0) begin
      z = (yv >= 0) ? 4 * qpi : -4 * qpi;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STAGES; i++) begin
      sx = yv >>> i;
      sy = xv >>> i;
      if (yv >= 0) begin
        xv += sx; yv -= sy; z += atan_tab[i];
      end else begin
        xv -= sx; yv += sy; z -= atan_tab[i];
      end
    end
    mag = xv;
    return z;
  endfunction

  function automatic longint rad_deg(longint rad);
    longint unsigned m, d;
    m = (rad < 0) ? longint'(-rad) : rad;
    d = (m * DEG45 + longint'(qpi) / 2) / longint'(qpi);
    return (rad < 0) ? -longint'(d) : longint'(d);
  endfunction

  function automatic lonlat_t project_pixel(longint xp, longint yp);
    longint px, py, kmag, dummy, ang, lon, lat;
    longint unsigned m, r;
    lonlat_t res;
    px = (2 * (xp + frame_ox) - frame_fw) * frame_scale;
    py = (frame_fw - 2 * (yp + frame_oy)) * frame_scale;
    ang = vector_angle(py, px, kmag);
    if (py == 0) begin
      lon = (px > 0) ? D90 : -D90;
    end else begin
      lon = D180 - rad_deg(ang);
      if (lon > D180) lon -= D360;
      if (lon <= -D180) lon += D360;
    end
    m = kmag;
    r = (m >> 32) * GAIN_INV + (((m & 64'hFFFFFFFF) * GAIN_INV) >> 32);
    ang = vector_angle(64'sd1 << 33, longint'(r), dummy);
    lat = D90 - rad_deg(2 * ang);
    if (lat > D90) lat = D90;
    if (lat < -D90) lat = -D90;
    res.lon = lon[24:0];
    res.lat = lat[23:0];
    return res;
  endfunction

  // Result checker
  always @(posedge clk) begin
    lonlat_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_coords.size() == 0) begin
        $error("unexpected result lon=%0d lat=%0d", out_longitude, out_latitude);
        errors++;
      end else begin
        exp_r = pending_coords.pop_front();
        if (out_longitude !== exp_r.lon) begin
          $error("longitude expected %0d actual %0d", exp_r.lon, out_longitude);
          errors++;
        end
        if (out_latitude !== exp_r.lat) begin
          $error("latitude expected %0d actual %0d", exp_r.lat, out_latitude);
          errors++;
        end
      end
    end
  end

  // Receiver stall bursts
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_pixel(logic [15:0] xp, logic [15:0] yp);
    in_valid <= 1'b1;
    in_pixel_x <= xp;
    in_pixel_y <= yp;
    do @(posedge clk); while (in_stall);
    pending_coords.insert(pending_coords.size(), project_pixel(xp, yp));
    // sender gap
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
  endtask

  // Write enable stays high across back-to-back writes; the caller drops it
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_OFFSET_X: frame_ox = val[19:0];
      REG_OFFSET_Y: frame_oy = val[19:0];
      REG_FULL_WIDTH: frame_fw = val[20:0];
      REG_SCALE_FACTOR: frame_scale = val;
    endcase
  endtask

  task automatic set_frame(logic [31:0] ox, logic [31:0] oy, logic [31:0] fw,
                           logic [31:0] sc);
    drain();
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_FULL_WIDTH, fw);
    write_reg(REG_SCALE_FACTOR, sc);
    cfg_we <= 1'b0;
  endtask

  // Default frame: center, axes, corners, pole
  task automatic test_default_frame();
    send_pixel(16'd512, 16'd512);
    send_pixel(16'd600, 16'd512);
    send_pixel(16'd400, 16'd512);
    send_pixel(16'd512, 16'd100);
    send_pixel(16'd512, 16'd900);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'd1023, 16'd513);
  endtask

  // Zero scale, extreme offsets and widths out of range
  task automatic test_corner_frames();
    set_frame(32'd0, 32'd0, 32'd1024, 32'd0);
    send_pixel(16'd3, 16'd700);
    send_pixel(16'd512, 16'd512);
    set_frame(32'hFFFFF, 32'hFFFFF, 32'd0, 32'hFFFFFFFF);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd0, 16'd0);
    set_frame(32'd0, 32'd0, 32'h1FFFFF, 32'hFFFFFFFF);
    send_pixel(16'd0, 16'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'd0);
    set_frame(32'd0, 32'd0, 32'd1048576, 32'd1);
    send_pixel(16'd0, 16'hFFFF);
    send_pixel(16'd5, 16'd0);
  endtask

  task automatic random_phase(int count);
    logic [15:0] xp, yp;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        xp = 16'($urandom);
        yp = 16'($urandom);
      end else begin
        // mostly around the frame center to sweep angles near the pole
        xp = 16'(frame_fw / 2 - frame_ox + $urandom_range(0, 64) - 32);
        yp = 16'(frame_fw / 2 - frame_oy + $urandom_range(0, 64) - 32);
      end
      send_pixel(xp, yp);
    end
  endtask

  task automatic test_random_frames();
    set_frame(32'd0, 32'd0, 32'd1024, 32'd4194304);
    random_phase(80);
    set_frame(32'd300, 32'd200, 32'd2048, 32'd2097152);
    random_phase(80);
    set_frame($urandom_range(0, 32'hFFFFF), $urandom_range(0, 32'hFFFFF),
              $urandom_range(1, 32'h1FFFFF), $urandom);
    random_phase(80);
    set_frame(32'd0, 32'd0, 32'd65536, 32'hFFFFFFFF);
    random_phase(80);
    set_frame($urandom_range(0, 1000), $urandom_range(0, 1000),
              $urandom_range(512, 4096), $urandom_range(1, 32'h00FFFFFF));
    random_phase(80);
    drain();
    quiet = 1'b1;
    random_phase(80);
  endtask

  initial begin
    fill_atan_table();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_frame();
    test_corner_frames();
    test_random_frames();
    drain();
    if (errors == 0 && pending_coords.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/psll_pkg.sv
rtl/core/psll_cordic.sv
rtl/core/psll_deg.sv
rtl/core/polar_stereo_pixel_to_lonlat.sv
tb/sv/polar_stereo_pixel_to_lonlat_test.sv
